### rtl/rdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdu_pkg
// shared word types and fixed constants of the refraction direction unit
// ----------------------------------------------------------------------------
package rdu_pkg;

  localparam int IN_W     = 16;
  localparam int IOR_W    = 15;
  localparam int ETA_W    = 29;
  localparam int ETA_FRAC = 16;
  localparam int ETA2_W   = 41;
  localparam int ETA2_LO  = 21;

  localparam logic [ETA_W-1:0] RECIP_ONE = 29'h1000_0000;

  typedef struct packed {
    logic signed [IN_W-1:0]  incident_x;
    logic signed [IN_W-1:0]  incident_y;
    logic signed [IN_W-1:0]  incident_z;
    logic signed [IN_W-1:0]  normal_x;
    logic signed [IN_W-1:0]  normal_y;
    logic signed [IN_W-1:0]  normal_z;
    logic        [IOR_W-1:0] refraction_index;
  } in_word_t;

  typedef struct packed {
    logic signed [IN_W-1:0] refracted_x;
    logic signed [IN_W-1:0] refracted_y;
    logic signed [IN_W-1:0] refracted_z;
    logic                   total_reflection;
  } out_word_t;

endpackage

### rtl/rdu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdu_in_if
// input channel: valid, ready and one ray word
// ----------------------------------------------------------------------------
interface rdu_in_if;
  logic              valid;
  logic              ready;
  rdu_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/rdu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdu_out_if
// result channel: valid, ready and one refracted direction word
// ----------------------------------------------------------------------------
interface rdu_out_if;
  logic               valid;
  logic               ready;
  rdu_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/refract_direction_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refract_direction_unit_core
// snell refraction of a fixed point direction vector, fully pipelined
// ----------------------------------------------------------------------------
// The unit takes one word per clock and returns one refracted direction per
// word in order. The pipeline holds registers for the dot product and cosine,
// a 29-stage radix-2 divider for the reciprocal index, five arithmetic stages,
// a square root pipeline of FRAC_BITS + 1 stages (one root bit per stage), two
// stages for the normal term and the output register. A stall on the result
// side freezes every stage at once, so throughput is one word per cycle
// whenever out ready is high.
module refract_direction_unit_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  rdu_in_if.sink     in_if,
  rdu_out_if.source  out_if
);

  localparam int F     = FRAC_BITS;
  localparam int CAW   = F + 1;
  localparam int CSQW  = 2 * CAW;
  localparam int RW    = F + 1;
  localparam int REMW  = RW + 3;
  localparam int VW    = 2 * RW;
  localparam int ECW   = F + 14;
  localparam int ECPW  = F + 30;
  localparam int MW    = F + 15;
  localparam int MNW   = MW + 17;
  localparam int PW    = F + 43;
  localparam int PHW   = F + 21;
  localparam int PLW   = F + 22;
  localparam int T1W   = 31;
  localparam int EIW   = 46;
  localparam int SUMW  = MNW - F + 2;
  localparam int DIV_N = rdu_pkg::ETA_W;
  localparam int EW    = rdu_pkg::ETA_W;

  localparam longint ONE_L = longint'(1) << F;
  localparam longint HI_L  = (ONE_L < 32767) ? ONE_L : 32767;
  localparam longint LO_L  = (-ONE_L > -32768) ? -ONE_L : -32768;

  localparam logic [CAW-1:0]         ONE_C   = CAW'(ONE_L);
  localparam logic [33:0]            ONE_D   = 34'(ONE_L);
  localparam logic [33:0]            HALF_D  = 34'(1) << (F - 1);
  localparam logic [CSQW-1:0]        ONE_SQ  = CSQW'(1) << (2 * F);
  localparam logic [CSQW-1:0]        HALF_SQ = CSQW'(1) << (F - 1);
  localparam logic [PW-1:0]          P_LIM   = PW'(1) << (F + 16);
  localparam logic [MNW-1:0]         HALF_MN = MNW'(1) << (F - 1);
  localparam logic signed [SUMW-1:0] SAT_HI  = SUMW'(HI_L);
  localparam logic signed [SUMW-1:0] SAT_LO  = SUMW'(LO_L);

  typedef struct packed {
    logic [2:0][15:0]  inc;
    logic [2:0][16:0]  n;
    logic [CAW-1:0]    cabs;
    logic              bneg;
    logic [14:0]       ior;
  } carry_t;

  typedef struct packed {
    carry_t            c;
    logic [EW-1:0]     num;
    logic [14:0]       rem;
    logic [EW-1:0]     q;
  } div_t;

  typedef struct packed {
    logic              tir;
    logic [2:0][T1W-1:0] t1;
    logic [ECW-1:0]    ec;
    logic [2:0][16:0]  n;
    logic [VW-1:0]     vsh;
    logic [REMW-1:0]   rem;
    logic [RW-1:0]     root;
  } sq_t;

  logic en;
  logic out_valid_r;
  rdu_pkg::out_word_t out_word_r;

  assign en           = !out_valid_r || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_word_r;

  // stage 1: products of the dot
  logic v1_r;
  logic signed [31:0] prod1_r [3];
  logic signed [15:0] inc1_r [3];
  logic signed [15:0] nrm1_r [3];
  logic [14:0] ior1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inc1_r[0]  <= in_if.data.incident_x;
      inc1_r[1]  <= in_if.data.incident_y;
      inc1_r[2]  <= in_if.data.incident_z;
      nrm1_r[0]  <= in_if.data.normal_x;
      nrm1_r[1]  <= in_if.data.normal_y;
      nrm1_r[2]  <= in_if.data.normal_z;
      prod1_r[0] <= in_if.data.incident_x * in_if.data.normal_x;
      prod1_r[1] <= in_if.data.incident_y * in_if.data.normal_y;
      prod1_r[2] <= in_if.data.incident_z * in_if.data.normal_z;
      ior1_r     <= (in_if.data.refraction_index == '0) ? 15'd1
                                                        : in_if.data.refraction_index;
    end
  end

  // stage 2: cosine, branch and oriented normal
  logic v2_r;
  carry_t c2_r, c2_nxt;
  logic signed [33:0] dot;
  logic [33:0] dmag, dround;
  logic dneg;

  always_comb begin
    dot    = 34'(prod1_r[0]) + 34'(prod1_r[1]) + 34'(prod1_r[2]);
    dneg   = dot[33];
    dmag   = dneg ? 34'(-dot) : 34'(dot);
    dround = (dmag + HALF_D) >> F;
    c2_nxt.cabs = (dround > ONE_D) ? ONE_C : dround[CAW-1:0];
    c2_nxt.bneg = dneg && (dround != '0);
    c2_nxt.ior  = ior1_r;
    for (int i = 0; i < 3; i++) begin
      c2_nxt.inc[i] = inc1_r[i];
      c2_nxt.n[i]   = c2_nxt.bneg ? 17'(nrm1_r[i]) : 17'(-(17'(nrm1_r[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= c2_nxt;
    end
  end

  // reciprocal index: one quotient bit per stage
  div_t div_in;
  div_t div_r [DIV_N];
  logic [DIV_N-1:0] dv_r;

  always_comb begin
    div_in.c   = c2_r;
    div_in.num = rdu_pkg::RECIP_ONE + EW'(c2_r.ior[14:1]);
    div_in.rem = '0;
    div_in.q   = '0;
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    div_t src;
    logic [15:0] t;
    logic ge;

    assign src = (j == 0) ? div_in : div_r[(j == 0) ? 0 : j - 1];
    assign t   = {src.rem, src.num[EW-1]};
    assign ge  = t >= {1'b0, src.c.ior};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= (j == 0) ? v2_r : dv_r[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[j].c   <= src.c;
        div_r[j].num <= src.num << 1;
        div_r[j].rem <= ge ? 15'(t - {1'b0, src.c.ior}) : t[14:0];
        div_r[j].q   <= {src.q[EW-2:0], ge};
      end
    end
  end

  // stage 3: pick eta
  logic v3_r;
  logic [EW-1:0] eta3_r;
  logic [CAW-1:0] cabs3_r;
  logic [2:0][15:0] inc3_r;
  logic [2:0][16:0] n3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= dv_r[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eta3_r  <= div_r[DIV_N-1].c.bneg ? div_r[DIV_N-1].q
                                       : EW'({div_r[DIV_N-1].c.ior, 4'b0000});
      cabs3_r <= div_r[DIV_N-1].c.cabs;
      inc3_r  <= div_r[DIV_N-1].c.inc;
      n3_r    <= div_r[DIV_N-1].c.n;
    end
  end

  // stage 4: squares and eta products
  logic v4_r;
  logic [2*EW-1:0] etasq4_r;
  logic [CSQW-1:0] csq4_r;
  logic signed [EIW-1:0] ei4_r [3];
  logic [ECPW-1:0] ec4_r;
  logic [2:0][16:0] n4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      etasq4_r <= eta3_r * eta3_r;
      csq4_r   <= CSQW'(cabs3_r) * CSQW'(cabs3_r);
      ec4_r    <= ECPW'(eta3_r) * ECPW'(cabs3_r);
      n4_r     <= n3_r;
      for (int i = 0; i < 3; i++) begin
        ei4_r[i] <= $signed({1'b0, eta3_r}) * $signed(inc3_r[i]);
      end
    end
  end

  // stage 5: roundings
  logic v5_r;
  logic [rdu_pkg::ETA2_W-1:0] eta2_5_r;
  logic [CAW-1:0] s5_r;
  logic [2:0][T1W-1:0] t1_5_r, t1_nxt;
  logic [ECW-1:0] ec5_r;
  logic [2:0][16:0] n5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [EIW-1:0] mg;
      logic [EIW-1:0] rr;
      mg = ei4_r[i][EIW-1] ? EIW'(-ei4_r[i]) : EIW'(ei4_r[i]);
      rr = (mg + EIW'(1 << 15)) >> rdu_pkg::ETA_FRAC;
      t1_nxt[i] = ei4_r[i][EIW-1] ? T1W'(-rr) : T1W'(rr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eta2_5_r <= rdu_pkg::ETA2_W'((etasq4_r + (2*EW)'(1 << 15)) >> rdu_pkg::ETA_FRAC);
      s5_r     <= CAW'((ONE_SQ - csq4_r + HALF_SQ) >> F);
      ec5_r    <= ECW'((ec4_r + ECPW'(1 << 15)) >> rdu_pkg::ETA_FRAC);
      t1_5_r   <= t1_nxt;
      n5_r     <= n4_r;
    end
  end

  // stage 6: eta^2 (1 - c^2) as two partial products
  logic v6_r;
  logic [PHW-1:0] ph6_r;
  logic [PLW-1:0] pl6_r;
  logic [2:0][T1W-1:0] t1_6_r;
  logic [ECW-1:0] ec6_r;
  logic [2:0][16:0] n6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph6_r  <= PHW'(eta2_5_r[rdu_pkg::ETA2_W-1:rdu_pkg::ETA2_LO]) * PHW'(s5_r);
      pl6_r  <= PLW'(eta2_5_r[rdu_pkg::ETA2_LO-1:0]) * PLW'(s5_r);
      t1_6_r <= t1_5_r;
      ec6_r  <= ec5_r;
      n6_r   <= n5_r;
    end
  end

  // stage 7: total reflection test and k
  logic v7_r;
  logic tir7_r;
  logic [CAW-1:0] k7_r;
  logic [2:0][T1W-1:0] t1_7_r;
  logic [ECW-1:0] ec7_r;
  logic [2:0][16:0] n7_r;
  logic [PW-1:0] p7, pr7;
  logic tir7;

  always_comb begin
    p7   = (PW'(ph6_r) << rdu_pkg::ETA2_LO) + PW'(pl6_r);
    tir7 = p7 > P_LIM;
    pr7  = (p7 + PW'(1 << 15)) >> rdu_pkg::ETA_FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir7_r <= tir7;
      k7_r   <= tir7 ? '0 : ONE_C - pr7[CAW-1:0];
      t1_7_r <= t1_6_r;
      ec7_r  <= ec6_r;
      n7_r   <= n6_r;
    end
  end

  // square root of k << F, one root bit per stage
  sq_t sq_in;
  sq_t sq_r [RW];
  logic [RW-1:0] sv_r;

  always_comb begin
    sq_in.tir  = tir7_r;
    sq_in.t1   = t1_7_r;
    sq_in.ec   = ec7_r;
    sq_in.n    = n7_r;
    sq_in.vsh  = {1'b0, k7_r, F'(0)};
    sq_in.rem  = '0;
    sq_in.root = '0;
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    sq_t src;
    logic [REMW-1:0] tr, trial;
    logic ge;

    assign src   = (j == 0) ? sq_in : sq_r[(j == 0) ? 0 : j - 1];
    assign tr    = {src.rem[REMW-3:0], src.vsh[VW-1 -: 2]};
    assign trial = REMW'({src.root, 2'b01});
    assign ge    = tr >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j] <= 1'b0;
      end else if (en) begin
        sv_r[j] <= (j == 0) ? v7_r : sv_r[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[j].tir  <= src.tir;
        sq_r[j].t1   <= src.t1;
        sq_r[j].ec   <= src.ec;
        sq_r[j].n    <= src.n;
        sq_r[j].vsh  <= src.vsh << 2;
        sq_r[j].rem  <= ge ? tr - trial : tr;
        sq_r[j].root <= {src.root[RW-2:0], ge};
      end
    end
  end

  // stage 8: normal scale
  logic v8_r;
  logic signed [MW-1:0] m8_r;
  logic tir8_r;
  logic [2:0][T1W-1:0] t1_8_r;
  logic [2:0][16:0] n8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= sv_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m8_r   <= $signed(MW'(sq_r[RW-1].ec)) - $signed(MW'(sq_r[RW-1].root));
      tir8_r <= sq_r[RW-1].tir;
      t1_8_r <= sq_r[RW-1].t1;
      n8_r   <= sq_r[RW-1].n;
    end
  end

  // stage 9: normal term products
  logic v9_r;
  logic signed [MNW-1:0] mn9_r [3];
  logic tir9_r;
  logic [2:0][T1W-1:0] t1_9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mn9_r[i] <= m8_r * $signed(n8_r[i]);
      end
      tir9_r <= tir8_r;
      t1_9_r <= t1_8_r;
    end
  end

  // output: round, sum, saturate
  logic [2:0][15:0] res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [MNW-1:0] mg;
      logic [MNW-1:0] rr;
      logic signed [SUMW-1:0] t2;
      logic signed [SUMW-1:0] sm;
      mg = mn9_r[i][MNW-1] ? MNW'(-mn9_r[i]) : MNW'(mn9_r[i]);
      rr = (mg + HALF_MN) >> F;
      t2 = mn9_r[i][MNW-1] ? -$signed(SUMW'(rr)) : $signed(SUMW'(rr));
      sm = $signed(SUMW'($signed(t1_9_r[i]))) + t2;
      priority if (tir9_r) begin
        res[i] = '0;
      end else if (sm > SAT_HI) begin
        res[i] = 16'(SAT_HI);
      end else if (sm < SAT_LO) begin
        res[i] = 16'(SAT_LO);
      end else begin
        res[i] = 16'(sm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r.refracted_x      <= res[0];
      out_word_r.refracted_y      <= res[1];
      out_word_r.refracted_z      <= res[2];
      out_word_r.total_reflection <= tir9_r;
    end
  end

`ifndef SYNTHESIS
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.total_reflection |->
      out_word_r.refracted_x == '0 && out_word_r.refracted_y == '0 &&
      out_word_r.refracted_z == '0)
    else $error("total reflection word with nonzero direction");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      $signed(SUMW'(out_word_r.refracted_x)) <= SAT_HI &&
      $signed(SUMW'(out_word_r.refracted_x)) >= SAT_LO)
    else $error("refracted x outside unit range");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r && !tir7_r |-> k7_r <= ONE_C)
    else $error("k above one without total reflection");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v9_r) && $stable(sv_r) && $stable(dv_r))
    else $error("pipeline moved during output stall");
`endif

endmodule

### dv/refract_direction_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refract_direction_unit_core_tb
// streams ray words through the refraction unit under bursty input and a
// stalling result side, predicts each refracted direction in fixed point and
// compares every result word field by field, in order
// ----------------------------------------------------------------------------
module refract_direction_unit_core_tb;

  localparam int FB       = 14;
  localparam int ONE      = 1 << FB;
  localparam int N_RAND   = 1950;
  localparam int WD_LIMIT = 20000;
  localparam int LAT      = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rdu_in_if  in_ch ();
  rdu_out_if out_ch ();

  refract_direction_unit_core #(.FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rdu_pkg::in_word_t  ray_q[$];
  rdu_pkg::out_word_t refr_q[$];
  int        errors = 0;
  int        watchdog = 0;
  bit        hold_long = 1'b0;
  bit        drain_req = 1'b0;
  bit        stim_done = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_ph = 0;

  function automatic longint rnd_away(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint unsigned rnd_up(longint unsigned v, int sh);
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_dir(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return v[15:0];
  endfunction

  function automatic rdu_pkg::out_word_t refract(rdu_pkg::in_word_t w);
    rdu_pkg::out_word_t o;
    longint inc[3], nrm[3], n[3];
    longint dot, c, m, t1, t2;
    longint unsigned ior, eta, eta2, s, p, k, root;
    inc[0] = w.incident_x; inc[1] = w.incident_y; inc[2] = w.incident_z;
    nrm[0] = w.normal_x;   nrm[1] = w.normal_y;   nrm[2] = w.normal_z;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += inc[i] * nrm[i];
    ior = w.refraction_index;
    if (ior == 0) ior = 1;
    c = rnd_away(dot, FB);
    if (c > ONE) c = ONE;
    if (c < -ONE) c = -ONE;
    if (c < 0) begin
      c = -c;
      eta = ((64'd1 << 28) + (ior >> 1)) / ior;
      for (int i = 0; i < 3; i++) n[i] = nrm[i];
    end else begin
      eta = ior << 4;
      for (int i = 0; i < 3; i++) n[i] = -nrm[i];
    end
    eta2 = rnd_up(eta * eta, 16);
    s = rnd_up(longint'(ONE) * ONE - c * c, FB);
    if (s != 0 && eta2 > 64'hFFFF_FFFF_FFFF_FFFF / s) p = 64'hFFFF_FFFF_FFFF_FFFF;
    else p = eta2 * s;
    o = '0;
    if (p > (longint'(ONE) << 16)) begin
      o.total_reflection = 1'b1;
      return o;
    end
    k = ONE - rnd_up(p, 16);
    root = int_sqrt(k << FB);
    m = rnd_away(longint'(eta) * c, 16) - longint'(root);
    t1 = rnd_away(longint'(eta) * inc[0], 16) + rnd_away(m * n[0], FB);
    o.refracted_x = sat_dir(t1);
    t1 = rnd_away(longint'(eta) * inc[1], 16) + rnd_away(m * n[1], FB);
    o.refracted_y = sat_dir(t1);
    t2 = rnd_away(longint'(eta) * inc[2], 16) + rnd_away(m * n[2], FB);
    o.refracted_z = sat_dir(t2);
    return o;
  endfunction

  function automatic logic signed [15:0] rnd_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'(signed'($urandom()));
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  // roughly unit vector with random direction
  function automatic void unit_vec(output logic signed [15:0] x, y, z);
    real a, b, cx, cy, cz;
    a = $urandom_range(0, 62831) / 10000.0;
    b = ($urandom_range(0, 20000) / 10000.0) - 1.0;
    cz = b;
    cx = $sqrt(1.0 - b * b) * $cos(a);
    cy = $sqrt(1.0 - b * b) * $sin(a);
    x = 16'($rtoi(cx * ONE));
    y = 16'($rtoi(cy * ONE));
    z = 16'($rtoi(cz * ONE));
  endfunction

  function automatic rdu_pkg::in_word_t mk(int ix, int iy, int iz, int nx, int ny, int nz,
                                           int ior);
    rdu_pkg::in_word_t w;
    w.incident_x = 16'(ix); w.incident_y = 16'(iy); w.incident_z = 16'(iz);
    w.normal_x   = 16'(nx); w.normal_y   = 16'(ny); w.normal_z   = 16'(nz);
    w.refraction_index = 15'(ior);
    return w;
  endfunction

  initial begin
    rdu_pkg::in_word_t w;
    int r;
    ray_q.push_back(mk(0, 0, -ONE, 0, 0, ONE, 6144));
    ray_q.push_back(mk(0, 0, ONE, 0, 0, ONE, 6144));
    ray_q.push_back(mk(ONE, 0, 0, 0, 0, ONE, 4096));
    ray_q.push_back(mk(11585, 0, -11585, 0, 0, ONE, 6144));
    ray_q.push_back(mk(11585, 0, 11585, 0, 0, ONE, 6144));
    ray_q.push_back(mk(11585, 0, -11585, 0, 0, ONE, 1));
    ray_q.push_back(mk(11585, 0, -11585, 0, 0, ONE, 32767));
    ray_q.push_back(mk(11585, 0, -11585, 0, 0, ONE, 0));
    ray_q.push_back(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE, 4096));
    ray_q.push_back(mk(ONE, ONE, ONE, ONE, ONE, ONE, 2048));
    ray_q.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767, 32767));
    ray_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 1));
    ray_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0));
    ray_q.push_back(mk(0, 0, 0, 0, 0, 0, 4096));
    ray_q.push_back(mk(9000, 0, 0, 0, 0, ONE, 6000));
    ray_q.push_back(mk(15000, 0, -6000, 0, 0, ONE, 2000));
    ray_q.push_back(mk(-16384, 0, -1, 0, 0, ONE, 8192));
    ray_q.push_back(mk(1, -1, 1, -1, 1, -1, 16383));
    for (int i = 0; i < N_RAND; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        unit_vec(w.incident_x, w.incident_y, w.incident_z);
        unit_vec(w.normal_x, w.normal_y, w.normal_z);
        w.refraction_index = 15'($urandom_range(3000, 12000));
      end else if (r < 9) begin
        w.incident_x = rnd_comp(); w.incident_y = rnd_comp(); w.incident_z = rnd_comp();
        w.normal_x = rnd_comp();   w.normal_y = rnd_comp();   w.normal_z = rnd_comp();
        w.refraction_index = 15'($urandom());
      end else begin
        w = rdu_pkg::in_word_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      end
      ray_q.push_back(w);
    end
    stim_done = 1'b1;
  end

  // long result-side hold while the driver keeps offering input
  initial begin
    repeat (400) @(posedge clk);
    hold_long <= 1'b1;
    repeat (300) @(posedge clk);
    hold_long <= 1'b0;
  end

  // sender pauses once until all results are back
  initial begin
    repeat (1500) @(posedge clk);
    drain_req <= 1'b1;
    wait (refr_q.size() == 0);
    @(posedge clk);
    drain_req <= 1'b0;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        refr_q.push_back(refract(in_ch.data));
        void'(ray_q.pop_front());
      end
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (drain_req || ray_q.size() == 0) begin
        if (!(in_ch.valid && !in_ch.ready)) in_ch.valid <= 1'b0;
      end else if (in_ch.valid && !in_ch.ready) begin
        // hold current word
      end else if (burst_left > 0) begin
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= ray_q[0];
      end else begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and result-side stall pattern
  always @(posedge clk) begin
    rdu_pkg::out_word_t exp_w;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (refr_q.size() == 0) begin
          $error("unexpected result word %h", out_ch.data);
          errors++;
        end else begin
          exp_w = refr_q.pop_front();
          if (out_ch.data.refracted_x !== exp_w.refracted_x) begin
            $error("refracted_x exp %0d got %0d", exp_w.refracted_x,
                   out_ch.data.refracted_x);
            errors++;
          end
          if (out_ch.data.refracted_y !== exp_w.refracted_y) begin
            $error("refracted_y exp %0d got %0d", exp_w.refracted_y,
                   out_ch.data.refracted_y);
            errors++;
          end
          if (out_ch.data.refracted_z !== exp_w.refracted_z) begin
            $error("refracted_z exp %0d got %0d", exp_w.refracted_z,
                   out_ch.data.refracted_z);
            errors++;
          end
          if (out_ch.data.total_reflection !== exp_w.total_reflection) begin
            $error("total_reflection exp %0b got %0b", exp_w.total_reflection,
                   out_ch.data.total_reflection);
            errors++;
          end
        end
      end
      stall_ph = (stall_ph + 1) % 1024;
      out_ch.ready <= !hold_long && (stall_ph < 256 || (stall_ph % 7) > 1);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WD_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (stim_done && rst_n);
    wait (ray_q.size() == 0 && refr_q.size() == 0);
    repeat (LAT * 2) @(posedge clk);
    if (errors == 0 && refr_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
